// ----- sv/rmes_pkg.sv -----
`timescale 1ns / 1ps
// Package for the rate monotonic / EDF scheduler: sizes, commands, register indexes,
// the task parameter and job state words kept in memory, and saturating add.
// No dependencies.
package rmes_pkg;

   localparam int MAX_TASKS = 16;
   localparam int TASK_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic {
      CSR_POLICY = 1'b0,
      CSR_TASKS  = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [15:0] len;
      logic [15:0] per;
   } param_type;

   typedef struct packed {
      logic [15:0] rem;
      logic [31:0] nxt;
      logic [31:0] dl;
   } job_type;

   typedef struct packed {
      logic        rel;
      logic        cand;
      logic [31:0] key;
      job_type     job;
   } eval_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ----- sv/rmes_ram.sv -----
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module rmes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- sv/rmes_eval.sv -----
`timescale 1ns / 1ps
// Per-slot evaluation during a tick scan: job release, EDF deadline, selection key.
// Depends on rmes_pkg.
module rmes_eval (
   input  logic                policy,
   input  logic [31:0]         now,
   input  rmes_pkg::param_type prm,
   input  rmes_pkg::job_type   job,
   output rmes_pkg::eval_type  ev
);
   import rmes_pkg::*;

   always_comb begin
      ev.rel = (now >= job.nxt) && (job.rem == 16'd0);
      ev.job = job;
      if (ev.rel) begin
         ev.job.rem = prm.len;
         if (policy) begin
            ev.job.dl = sat_add32(now, {16'd0, prm.per});
         end
      end
      ev.cand = (ev.job.rem != 16'd0);
      ev.key  = policy ? ev.job.dl : {16'd0, prm.per};
   end

endmodule

// ----- sv/rate_monotonic_edf_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Top level of the rate monotonic / EDF scheduler: control, job state memories, output word.
// Depends on rmes_pkg, rmes_ram and rmes_eval.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | command, task_index, exec_time, task_period
//   rsp     | out       | rsp_valid/rsp_stall  | tick_time, task_ran, running_task, job_finished
//   csr     | in        | csr_wr_en            | csr_index, csr_wr_data
//
// A tick scans n slots, n being the clamped task count: one memory read per slot through
// the shared read address, then the wait for read data, closing the scan, updating the chosen
// job, loading the output word (held off while a stalled word is pending) and the return
// to idle. Load, restart and unknown commands go from idle straight to loading the output
// word. Reset clears time, registers and all job state at once. A stalled output word
// holds while the next word is accepted.
module rate_monotonic_edf_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_task_index,
   input  logic [15:0] req_exec_time,
   input  logic [15:0] req_task_period,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_tick_time,
   output logic        rsp_task_ran,
   output logic [3:0]  rsp_running_task,
   output logic        rsp_job_finished,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [4:0]  csr_wr_data
);
   import rmes_pkg::*;

   state_type             state_ff, state_in;
   logic                  policy_ff, policy_in;
   logic [4:0]            tasks_ff, tasks_in;
   logic [31:0]           time_ff, time_in;
   logic [MAX_TASKS-1:0]  vld_ff, vld_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  dv_ff, dv_in;
   logic [TASK_W-1:0]     dv_idx_ff, dv_idx_in;
   logic                  sel_found_ff, sel_found_in;
   logic [TASK_W-1:0]     sel_idx_ff, sel_idx_in;
   logic [31:0]           sel_key_ff, sel_key_in;
   logic [15:0]           sel_per_ff, sel_per_in;
   job_type               sel_job_ff, sel_job_in;
   logic [31:0]           res_time_ff, res_time_in;
   logic                  res_ran_ff, res_ran_in;
   logic [3:0]            res_task_ff, res_task_in;
   logic                  res_fin_ff, res_fin_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_time_ff, rsp_time_in;
   logic                  rsp_ran_ff, rsp_ran_in;
   logic [3:0]            rsp_task_ff, rsp_task_in;
   logic                  rsp_fin_ff, rsp_fin_in;

   logic                  prm_we;
   logic [TASK_W-1:0]     prm_wa;
   param_type             prm_wd;
   param_type             prm_rd;
   logic                  job_we;
   logic [TASK_W-1:0]     job_wa;
   job_type               job_wd;
   job_type               job_rd;
   job_type               job_q;
   logic                  rd_en;
   logic [TASK_W-1:0]     rd_addr;
   eval_type              ev;
   job_type               fin_job;

   rmes_ram #(.WIDTH($bits(param_type)), .DEPTH(MAX_TASKS)) u_prm_ram (
      .clock   (clock),
      .wr_en   (prm_we),
      .wr_addr (prm_wa),
      .wr_data (prm_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prm_rd)
   );

   rmes_ram #(.WIDTH($bits(job_type)), .DEPTH(MAX_TASKS)) u_job_ram (
      .clock   (clock),
      .wr_en   (job_we),
      .wr_addr (job_wa),
      .wr_data (job_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (job_rd)
   );

   // job state never written since load or restart reads as zero
   assign job_q = vld_ff[dv_idx_ff] ? job_rd : '0;

   rmes_eval u_eval (
      .policy (policy_ff),
      .now    (time_ff),
      .prm    (prm_rd),
      .job    (job_q),
      .ev     (ev)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tick_time    = rsp_time_ff;
   assign rsp_task_ran     = rsp_ran_ff;
   assign rsp_running_task = rsp_task_ff;
   assign rsp_job_finished = rsp_fin_ff;

   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      tasks_in     = tasks_ff;
      time_in      = time_ff;
      vld_in       = vld_ff;
      n_in         = n_ff;
      rd_idx_in    = rd_idx_ff;
      dv_in        = 1'b0;
      dv_idx_in    = dv_idx_ff;
      sel_found_in = sel_found_ff;
      sel_idx_in   = sel_idx_ff;
      sel_key_in   = sel_key_ff;
      sel_per_in   = sel_per_ff;
      sel_job_in   = sel_job_ff;
      res_time_in  = res_time_ff;
      res_ran_in   = res_ran_ff;
      res_task_in  = res_task_ff;
      res_fin_in   = res_fin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_time_in  = rsp_time_ff;
      rsp_ran_in   = rsp_ran_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_fin_in   = rsp_fin_ff;
      prm_we       = 1'b0;
      prm_wa       = TASK_W'(req_task_index);
      prm_wd       = '{len: req_exec_time, per: req_task_period};
      job_we       = 1'b0;
      job_wa       = dv_idx_ff;
      job_wd       = ev.job;
      rd_en        = 1'b0;
      rd_addr      = rd_idx_ff[TASK_W-1:0];
      fin_job      = sel_job_ff;

      if (csr_wr_en) begin
         unique case (csr_type'(csr_index))
            CSR_POLICY: policy_in = csr_wr_data[0];
            CSR_TASKS:  tasks_in  = csr_wr_data;
            default:    ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_time_in = '0;
               res_ran_in  = 1'b0;
               res_task_in = '0;
               res_fin_in  = 1'b0;
               state_in    = ST_DONE;
               unique case (cmd_type'(req_command))
                  CMD_LOAD: begin
                     if (32'(req_task_index) < 32'(MAX_TASKS)) begin
                        prm_we         = 1'b1;
                        vld_in[prm_wa] = 1'b0;
                     end
                  end
                  CMD_TICK: begin
                     if (32'(tasks_ff) > 32'(MAX_TASKS)) begin
                        n_in = CNT_W'(MAX_TASKS);
                     end else begin
                        n_in = CNT_W'(tasks_ff);
                     end
                     rd_idx_in    = '0;
                     sel_found_in = 1'b0;
                     state_in     = ST_SCAN;
                  end
                  CMD_RESTART: begin
                     vld_in  = '0;
                     time_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff != n_ff) begin
               rd_en     = 1'b1;
               dv_in     = 1'b1;
               dv_idx_in = rd_idx_ff[TASK_W-1:0];
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (dv_ff) begin
               if (ev.rel) begin
                  job_we            = 1'b1;
                  vld_in[dv_idx_ff] = 1'b1;
               end
               if (ev.cand && (!sel_found_ff || (ev.key < sel_key_ff))) begin
                  sel_found_in = 1'b1;
                  sel_idx_in   = dv_idx_ff;
                  sel_key_in   = ev.key;
                  sel_per_in   = prm_rd.per;
                  sel_job_in   = ev.job;
               end
            end
            if ((rd_idx_ff == n_ff) && !dv_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            res_time_in = time_ff;
            res_ran_in  = 1'b0;
            res_task_in = '0;
            res_fin_in  = 1'b0;
            if (time_ff != 32'hFFFF_FFFF) begin
               time_in = time_ff + 32'd1;
            end
            if (sel_found_ff) begin
               fin_job.rem = sel_job_ff.rem - 16'd1;
               if (fin_job.rem == 16'd0) begin
                  fin_job.nxt = sat_add32(sel_job_ff.nxt, {16'd0, sel_per_ff});
                  res_fin_in  = 1'b1;
               end
               res_ran_in         = 1'b1;
               res_task_in        = 4'(sel_idx_ff);
               job_we             = 1'b1;
               job_wa             = sel_idx_ff;
               job_wd             = fin_job;
               vld_in[sel_idx_ff] = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = res_time_ff;
               rsp_ran_in   = res_ran_ff;
               rsp_task_in  = res_task_ff;
               rsp_fin_in   = res_fin_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= 1'b0;
         tasks_ff     <= '0;
         time_ff      <= '0;
         vld_ff       <= '0;
         dv_ff        <= 1'b0;
         sel_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         tasks_ff     <= tasks_in;
         time_ff      <= time_in;
         vld_ff       <= vld_in;
         dv_ff        <= dv_in;
         sel_found_ff <= sel_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      rd_idx_ff   <= rd_idx_in;
      dv_idx_ff   <= dv_idx_in;
      sel_idx_ff  <= sel_idx_in;
      sel_key_ff  <= sel_key_in;
      sel_per_ff  <= sel_per_in;
      sel_job_ff  <= sel_job_in;
      res_time_ff <= res_time_in;
      res_ran_ff  <= res_ran_in;
      res_task_ff <= res_task_in;
      res_fin_ff  <= res_fin_in;
      rsp_time_ff <= rsp_time_in;
      rsp_ran_ff  <= rsp_ran_in;
      rsp_task_ff <= rsp_task_in;
      rsp_fin_ff  <= rsp_fin_in;
   end

endmodule

// ----- bench/schedule_checker.sv -----
`timescale 1ns / 1ps
// Scheduler checker: watches the req, rsp and csr ports, predicts each outgoing word
// and compares it field by field. Depends on rmes_pkg.
module schedule_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_task_index,
   input  logic [15:0] req_exec_time,
   input  logic [15:0] req_task_period,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_tick_time,
   input  logic        rsp_task_ran,
   input  logic [3:0]  rsp_running_task,
   input  logic        rsp_job_finished,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [4:0]  csr_wr_data,
   output int          fail_count,
   output int          outstanding,
   output int          checked
);
   import rmes_pkg::*;

   typedef struct packed {
      logic [31:0] at;
      logic        ran;
      logic [3:0]  who;
      logic        done;
   } decision_type;

   logic        edf_mode;
   logic [4:0]  task_limit;
   logic [15:0] job_len   [MAX_TASKS];
   logic [15:0] job_per   [MAX_TASKS];
   logic [15:0] work_left [MAX_TASKS];
   logic [31:0] release_at[MAX_TASKS];
   logic [31:0] deadline  [MAX_TASKS];
   logic [31:0] clock_now;

   decision_type pending_decisions[$];
   int n_fail = 0;
   int n_open = 0;
   int n_seen = 0;

   assign fail_count  = n_fail;
   assign outstanding = n_open;
   assign checked     = n_seen;

   initial begin
      foreach (job_len[i]) begin
         job_len[i] = '0;
         job_per[i] = '0;
      end
   end

   function automatic logic [31:0] sum_clamped(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void clear_jobs();
      for (int i = 0; i < MAX_TASKS; i++) begin
         work_left[i]  = '0;
         release_at[i] = '0;
         deadline[i]   = '0;
      end
      clock_now = '0;
   endfunction

   function automatic decision_type advance_scheduler(logic [1:0] cmd, logic [3:0] idx,
                                                      logic [15:0] len, logic [15:0] per);
      decision_type d;
      int n;
      int sel;
      logic [31:0] now;
      d = '0;
      case (cmd)
         CMD_LOAD: begin
            job_len[idx]    = len;
            job_per[idx]    = per;
            work_left[idx]  = '0;
            release_at[idx] = '0;
            deadline[idx]   = '0;
         end
         CMD_RESTART: begin
            clear_jobs();
         end
         CMD_TICK: begin
            n   = (task_limit > MAX_TASKS) ? MAX_TASKS : int'(task_limit);
            now = clock_now;
            sel = -1;
            for (int i = 0; i < n; i++) begin
               if (now >= release_at[i] && work_left[i] == 0) begin
                  work_left[i] = job_len[i];
                  if (edf_mode)
                     deadline[i] = sum_clamped(now, {16'b0, job_per[i]});
               end
            end
            for (int i = 0; i < n; i++) begin
               if (work_left[i] != 0) begin
                  if (sel < 0)
                     sel = i;
                  else if (edf_mode ? (deadline[i] < deadline[sel])
                                    : (job_per[i] < job_per[sel]))
                     sel = i;
               end
            end
            d.at = now;
            if (sel >= 0) begin
               d.ran = 1'b1;
               d.who = 4'(sel);
               work_left[sel] = work_left[sel] - 16'd1;
               if (work_left[sel] == 0) begin
                  release_at[sel] = sum_clamped(release_at[sel], {16'b0, job_per[sel]});
                  d.done = 1'b1;
               end
            end
            if (clock_now != 32'hFFFF_FFFF)
               clock_now = clock_now + 32'd1;
         end
         default: ;
      endcase
      return d;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] MISMATCH word %0d: %s", $realtime, n_seen, msg);
      n_fail++;
   endtask

   always @(posedge clock) begin
      decision_type want;
      if (reset) begin
         edf_mode   = 1'b0;
         task_limit = '0;
         clear_jobs();
         pending_decisions.delete();
         n_open = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POLICY: edf_mode   = csr_wr_data[0];
               CSR_TASKS:  task_limit = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            pending_decisions.push_back(advance_scheduler(req_command, req_task_index,
                                                          req_exec_time, req_task_period));
            n_open++;
         end
         if (rsp_valid && !rsp_stall) begin
            n_seen++;
            if (pending_decisions.size() == 0) begin
               report_mismatch("word with nothing expected");
            end else begin
               want = pending_decisions.pop_front();
               n_open--;
               if (rsp_tick_time !== want.at)
                  report_mismatch($sformatf("tick_time expected %0d got %0d",
                                            want.at, rsp_tick_time));
               if (rsp_task_ran !== want.ran)
                  report_mismatch($sformatf("task_ran expected %0d got %0d",
                                            want.ran, rsp_task_ran));
               if (rsp_running_task !== want.who)
                  report_mismatch($sformatf("running_task expected %0d got %0d",
                                            want.who, rsp_running_task));
               if (rsp_job_finished !== want.done)
                  report_mismatch($sformatf("job_finished expected %0d got %0d",
                                            want.done, rsp_job_finished));
            end
         end
      end
   end

endmodule

// ----- bench/rate_monotonic_edf_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the RM/EDF scheduler: clock, reset, directed and random words,
// register settings and verdict. Depends on rmes_pkg, schedule_checker and the block.
module rate_monotonic_edf_scheduler_unit_tb;
   import rmes_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 30;
   localparam int N_PHASES       = 7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_LOAD;
   logic [3:0]  req_task_index = '0;
   logic [15:0] req_exec_time = '0;
   logic [15:0] req_task_period = 16'd1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_tick_time;
   logic        rsp_task_ran;
   logic [3:0]  rsp_running_task;
   logic        rsp_job_finished;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_POLICY;
   logic [4:0]  csr_wr_data = '0;

   int fail_count;
   int outstanding;
   int checked;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_requests = 0;
   int idle_run = 0;
   int n_load = 0;
   int n_tick = 0;
   int n_restart = 0;
   int n_unused = 0;

   // per-phase register settings and word counts
   bit         phase_edf  [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
   logic [4:0] phase_count[N_PHASES] = '{5'd16, 5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd16};
   int         phase_words[N_PHASES] = '{180, 180, 120, 140, 80, 30, 120};

   always #2 clock = ~clock;

   rate_monotonic_edf_scheduler_unit uut (.*);

   schedule_checker u_checker (.*);

   // receiver: random stall, plus a long hold-off on request
   initial begin
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_run <= 0;
      end else if (idle_run >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d words open",
                  idle_run, outstanding);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   task automatic send_word(logic [1:0] cmd, logic [3:0] idx, logic [15:0] len,
                            logic [15:0] per);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_task_index  <= idx;
      req_exec_time   <= len;
      req_task_period <= per;
      do @(posedge clock); while (req_stall);
      case (cmd)
         CMD_LOAD:    n_load++;
         CMD_TICK:    n_tick++;
         CMD_RESTART: n_restart++;
         default:     n_unused++;
      endcase
   endtask

   task automatic send_random_word();
      int pick;
      int s;
      logic [15:0] len;
      logic [15:0] per;
      pick = $urandom_range(99);
      if (pick < 68) begin
         send_word(CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 92) begin
         s = $urandom_range(99);
         if (s < 4)       len = 16'($urandom);
         else if (s < 12) len = '0;
         else             len = 16'($urandom_range(1, 5));
         s = $urandom_range(99);
         if (s < 5)       per = 16'($urandom_range(1, 65535));
         else if (s < 8)  per = 16'd1;
         else             per = 16'($urandom_range(2, 30));
         send_word(CMD_LOAD, 4'($urandom_range(15)), len, per);
      end else if (pick < 97) begin
         send_word(CMD_RESTART, 4'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         send_word(CMD_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   task automatic write_settings(bit edf, logic [4:0] count);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_POLICY;
      csr_wr_data <= {4'b0, edf};
      @(posedge clock);
      csr_index   <= CSR_TASKS;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 11;
      rsp_idle_pct = 50;

      // directed: fill every slot, then ticks, reload mid-job, unused code, restart
      write_settings(1'b0, 5'd16);
      send_word(CMD_LOAD, 4'd0, 16'd1, 16'd4);
      send_word(CMD_LOAD, 4'd1, 16'd2, 16'd4);
      send_word(CMD_LOAD, 4'd2, 16'd0, 16'd1);
      send_word(CMD_LOAD, 4'd3, 16'hFFFF, 16'hFFFF);
      send_word(CMD_LOAD, 4'd4, 16'd1, 16'd6);
      send_word(CMD_LOAD, 4'd5, 16'd1, 16'd6);
      for (int i = 6; i < MAX_TASKS; i++)
         send_word(CMD_LOAD, 4'(i), 16'((i % 3) + 1), 16'(20 + i));
      repeat (4) send_word(CMD_TICK, '0, '0, '0);
      send_word(CMD_LOAD, 4'd1, 16'd3, 16'd5);
      send_word(CMD_TICK, '1, '1, '1);
      send_word(CMD_UNUSED, '1, '1, '1);
      send_word(CMD_RESTART, '0, '0, '0);
      repeat (2) send_word(CMD_TICK, '0, '0, '0);
      drain();

      for (int p = 0; p < N_PHASES; p++) begin
         if (p < 2) begin
            req_idle_pct = 11;
            rsp_idle_pct = 50;
         end else if (p < 4) begin
            req_idle_pct = 50;
            rsp_idle_pct = 11;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         write_settings(phase_edf[p], phase_count[p]);
         if (p == N_PHASES - 1)
            hold_requests++;
         repeat (phase_words[p]) send_random_word();
         drain();
      end

      $display("Sent %0d load, %0d tick, %0d restart and %0d unused-code words; %0d checked",
               n_load, n_tick, n_restart, n_unused, checked);
      $display("Both policies, task counts 0 to 31, with sender, receiver and long stalls");
      if (fail_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- rate_monotonic_edf_scheduler_unit.f -----
sv/rmes_pkg.sv
sv/rmes_ram.sv
sv/rmes_eval.sv
sv/rate_monotonic_edf_scheduler_unit.sv
bench/schedule_checker.sv
bench/rate_monotonic_edf_scheduler_unit_tb.sv
